>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks sampled on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BFV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bfv assertion failed");

// next-cycle implication
`define BFV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bfv assertion failed");

`endif

>>> hw/rtl/bfv_pkg.sv
// ----------------------------------------------------------------------------
// bfv_pkg
// Shared types and constants of the flocking vector block.
// ----------------------------------------------------------------------------
package bfv_pkg;

    localparam int BFV_MAX_DRONES = 64;

    localparam int SWARM_W = 7;
    localparam int RAD_W   = 24;
    localparam int POS_W   = 32;
    localparam int VEL_W   = 16;
    localparam int ID_W    = 7;
    localparam int CFG_IDX_W = 2;

    localparam int DVD_W = 50;
    localparam int DVS_W = 25;
    localparam int RAD2_W = 48;
    localparam int ACC_W = 48;
    localparam int MUL_W = 26;
    localparam int ROOT_W = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_SWARM_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVOID_RAD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COH_RAD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_RAD  = 2'd3;

    localparam logic [SWARM_W-1:0] RST_SWARM_SIZE = 7'd4;
    localparam logic [RAD_W-1:0]   RST_AVOID_RAD  = 24'd512;
    localparam logic [RAD_W-1:0]   RST_COH_RAD    = 24'd5120;
    localparam logic [RAD_W-1:0]   RST_ALIGN_RAD  = 24'd2560;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_R2A, ST_R2C, ST_R2L, ST_RD, ST_WAIT, ST_SQN, ST_SQE,
        ST_TEST, ST_SQRT, ST_KN, ST_DIVN, ST_KE, ST_DIVE, ST_NEXT, ST_AVG, ST_AVGW,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             go;
        logic [DVD_W-1:0] num;
        logic [DVS_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic             go;
        logic [DVD_W-1:0] rad;
    } t_sqrt_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sqrt_rsp;

endpackage

>>> hw/rtl/bfv_div.sv
// ----------------------------------------------------------------------------
// bfv_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfv_div
    import bfv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_den;

    logic [DVS_W:0] sh;
    logic [DVS_W:0] diff;
    logic           fit;

    assign sh   = {r_rem, r_quo[DVD_W-1]};
    assign diff = sh - {1'b0, r_den};
    assign fit  = sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go && !r_busy) begin
            r_quo <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fit ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], fit};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

>>> hw/rtl/bfv_isqrt.sv
// ----------------------------------------------------------------------------
// bfv_isqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module bfv_isqrt
    import bfv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sqrt_req i_req,
    output t_sqrt_rsp o_rsp
);

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 3;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DVD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] trial;
    logic             fit;

    assign sh    = {r_rem[REM_W-3:0], r_rad[DVD_W-1:DVD_W-2]};
    assign trial = {1'b0, r_root, 2'b01};
    assign fit   = sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go && !r_busy) begin
            r_rad  <= i_req.rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[DVD_W-3:0], 2'b00};
            r_rem  <= fit ? (sh - trial) : sh;
            r_root <= {r_root[ROOT_W-2:0], fit};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

>>> hw/rtl/boids_flocking_vectors.sv
// ----------------------------------------------------------------------------
// boids_flocking_vectors
// Separation, cohesion and alignment vectors for a pinging drone.
//
//   channel | direction | handshake                | beat
//   in      | in        | i_in_valid / o_in_stall  | id, position, velocity
//   out     | out       | o_out_valid / i_out_stall| target id, flag, vectors
//   cfg     | in        | i_cfg_valid / o_cfg_ready| register index, data
//
// After reset the tables are cleared, with o_in_stall high.
// Per item: the three radius squares, then per slot a table read and distance
// square, cut short when out of range, plus a root and two divides for another
// slot at nonzero distance inside the avoid radius, then per vector a divide if
// its count is nonzero; all divides share one divider. Invalid ids skip this.
// A waiting result holds the block, and o_in_stall, until the output frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module boids_flocking_vectors
    import bfv_pkg::*;
#(
    parameter int MAX_DRONES = BFV_MAX_DRONES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ID_W-1:0]             i_drone_id,
    input  logic signed [POS_W-1:0]     i_pos_north,
    input  logic signed [POS_W-1:0]     i_pos_east,
    input  logic signed [VEL_W-1:0]     i_vel_north,
    input  logic signed [VEL_W-1:0]     i_vel_east,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ID_W-1:0]             o_target_id,
    output logic                        o_bad_id,
    output logic signed [POS_W-1:0]     o_cohesion_north,
    output logic signed [POS_W-1:0]     o_cohesion_east,
    output logic signed [VEL_W-1:0]     o_align_north,
    output logic signed [VEL_W-1:0]     o_align_east,
    output logic signed [POS_W-1:0]     o_separate_north,
    output logic signed [POS_W-1:0]     o_separate_east,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [RAD_W-1:0]            i_cfg_data
);

    localparam int AW = $clog2(MAX_DRONES);
    localparam int NW = $clog2(MAX_DRONES + 1);
    localparam int CW = (NW > ID_W) ? NW : ID_W;

    t_state r_state, n_state;

    logic [SWARM_W-1:0] r_swarm;
    logic [RAD_W-1:0]   r_ar, r_cr, r_lr;
    logic [RAD2_W-1:0]  r_ar2, r_cr2, r_lr2;

    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_self;
    logic [ID_W-1:0] r_id;
    logic          r_bad;
    logic signed [POS_W-1:0] r_pn, r_pe;

    logic [2*POS_W-1:0] r_pos_mem [MAX_DRONES];
    logic [2*VEL_W-1:0] r_vel_mem [MAX_DRONES];
    logic [2*POS_W-1:0] r_pos_rd;
    logic [2*VEL_W-1:0] r_vel_rd;

    logic signed [POS_W:0]   r_dn, r_de;
    logic                    r_far;
    logic signed [VEL_W-1:0] r_vn, r_ve;
    logic [DVD_W-1:0]        r_d2;
    logic [ROOT_W-1:0]       r_dist;
    logic                    r_neg;

    logic signed [ACC_W-1:0] r_sn, r_se, r_cn, r_ce, r_an, r_ae;
    logic [NW-1:0] r_nsep, r_ncoh, r_nali;
    logic [2:0]    r_k;
    logic [POS_W-1:0] r_avg [6];

    logic r_out_valid;
    logic [ID_W-1:0] r_o_id;
    logic r_o_bad;
    logic signed [POS_W-1:0] r_o_cn, r_o_ce, r_o_sn, r_o_se;
    logic signed [VEL_W-1:0] r_o_an, r_o_ae;

    logic [CW-1:0] n_eff;
    logic [CW-1:0] id_m1;
    logic          id_bad;
    logic          in_acc;
    logic          last;
    logic          out_free;

    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [2*POS_W-1:0] pos_wd;
    logic [2*VEL_W-1:0] vel_wd;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod;
    logic [DVD_W-1:0]          prod_mag;
    logic signed [MUL_W-1:0]   dn26, de26;
    logic [RAD_W-1:0]          kval;
    logic signed [POS_W:0]     dn_new, de_new;
    logic                      far_n, far_e;

    logic in_sep, in_coh, in_ali;

    logic signed [ACC_W-1:0] avg_acc;
    logic [NW-1:0]           avg_cnt;
    logic [ACC_W-1:0]        avg_mag;
    logic [ACC_W-1:0]        q48;
    logic [POS_W-1:0]        q32;

    t_div_req  div_req;
    t_div_rsp  div_rsp;
    t_sqrt_req sq_req;
    t_sqrt_rsp sq_rsp;

    bfv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    bfv_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_rsp   (sq_rsp)
    );

    assign n_eff  = (CW'(r_swarm) > CW'(MAX_DRONES)) ? CW'(MAX_DRONES) : CW'(r_swarm);
    assign id_m1  = CW'(i_drone_id) - 1'b1;
    assign id_bad = (i_drone_id == '0) || (CW'(i_drone_id) > n_eff);
    assign in_acc = i_in_valid && !o_in_stall;
    assign last   = (CW'(r_i) == (n_eff - 1'b1));
    assign out_free = !r_out_valid || !i_out_stall;

    assign prod     = mul_a * mul_b;
    assign prod_mag = prod[2*MUL_W-1] ? DVD_W'(-prod) : DVD_W'(prod);
    assign dn26     = r_dn[MUL_W-1:0];
    assign de26     = r_de[MUL_W-1:0];
    assign kval     = r_ar - r_dist[RAD_W-1:0];

    assign dn_new = (POS_W+1)'(r_pn) - (POS_W+1)'($signed(r_pos_rd[2*POS_W-1:POS_W]));
    assign de_new = (POS_W+1)'(r_pe) - (POS_W+1)'($signed(r_pos_rd[POS_W-1:0]));
    assign far_n  = !((dn_new[POS_W:RAD_W] == '0) ||
                      ((&dn_new[POS_W:RAD_W]) && (dn_new[RAD_W-1:0] != '0)));
    assign far_e  = !((de_new[POS_W:RAD_W] == '0) ||
                      ((&de_new[POS_W:RAD_W]) && (de_new[RAD_W-1:0] != '0)));

    assign in_sep = (r_d2 < {2'b00, r_ar2}) && (r_i != r_self);
    assign in_coh = r_d2 < {2'b00, r_cr2};
    assign in_ali = r_d2 < {2'b00, r_lr2};

    assign q48 = div_rsp.quo[ACC_W-1:0];
    assign q32 = div_rsp.quo[POS_W-1:0];

    always_comb begin
        case (r_k)
            3'd0: begin avg_acc = r_cn; avg_cnt = r_ncoh; end
            3'd1: begin avg_acc = r_ce; avg_cnt = r_ncoh; end
            3'd2: begin avg_acc = r_an; avg_cnt = r_nali; end
            3'd3: begin avg_acc = r_ae; avg_cnt = r_nali; end
            3'd4: begin avg_acc = r_sn; avg_cnt = r_nsep; end
            3'd5: begin avg_acc = r_se; avg_cnt = r_nsep; end
            default: begin avg_acc = '0; avg_cnt = '0; end
        endcase
    end
    assign avg_mag = avg_acc[ACC_W-1] ? ACC_W'(-avg_acc) : ACC_W'(avg_acc);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == AW'(MAX_DRONES - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (in_acc) n_state = id_bad ? ST_DONE : ST_R2A;
            ST_R2A:   n_state = ST_R2C;
            ST_R2C:   n_state = ST_R2L;
            ST_R2L:   n_state = ST_RD;
            ST_RD:    n_state = ST_WAIT;
            ST_WAIT:  n_state = ST_SQN;
            ST_SQN:   n_state = r_far ? ST_NEXT : ST_SQE;
            ST_SQE:   n_state = ST_TEST;
            ST_TEST:  n_state = (in_sep && r_d2 != '0) ? ST_SQRT : ST_NEXT;
            ST_SQRT:  if (sq_rsp.done) n_state = ST_KN;
            ST_KN:    n_state = ST_DIVN;
            ST_DIVN:  if (div_rsp.done) n_state = ST_KE;
            ST_KE:    n_state = ST_DIVE;
            ST_DIVE:  if (div_rsp.done) n_state = ST_NEXT;
            ST_NEXT:  n_state = last ? ST_AVG : ST_RD;
            ST_AVG: begin
                if (avg_cnt != '0) n_state = ST_AVGW;
                else if (r_k == 3'd5) n_state = ST_DONE;
            end
            ST_AVGW:  if (div_rsp.done) n_state = (r_k == 3'd5) ? ST_DONE : ST_AVG;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        mem_we  = 1'b0;
        mem_wa  = r_clr;
        pos_wd  = '0;
        vel_wd  = '0;
        mul_a   = '0;
        mul_b   = '0;
        div_req = '0;
        sq_req  = '0;
        sq_req.rad = r_d2;
        case (r_state)
            ST_CLEAR: mem_we = 1'b1;
            ST_IDLE: begin
                o_in_stall = 1'b0;
                mem_we = i_in_valid && !id_bad;
                mem_wa = id_m1[AW-1:0];
                pos_wd = {i_pos_north, i_pos_east};
                vel_wd = {i_vel_north, i_vel_east};
            end
            ST_R2A: begin mul_a = {2'b00, r_ar}; mul_b = {2'b00, r_ar}; end
            ST_R2C: begin mul_a = {2'b00, r_cr}; mul_b = {2'b00, r_cr}; end
            ST_R2L: begin mul_a = {2'b00, r_lr}; mul_b = {2'b00, r_lr}; end
            ST_SQN: begin mul_a = dn26; mul_b = dn26; end
            ST_SQE: begin mul_a = de26; mul_b = de26; end
            ST_TEST: sq_req.go = in_sep && (r_d2 != '0);
            ST_KN: begin
                mul_a = {2'b00, kval};
                mul_b = dn26;
                div_req.go  = 1'b1;
                div_req.num = prod_mag;
                div_req.den = r_dist;
            end
            ST_KE: begin
                mul_a = {2'b00, kval};
                mul_b = de26;
                div_req.go  = 1'b1;
                div_req.num = prod_mag;
                div_req.den = r_dist;
            end
            ST_AVG: begin
                div_req.go  = avg_cnt != '0;
                div_req.num = {2'b00, avg_mag};
                div_req.den = DVS_W'(avg_cnt);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pos_mem[mem_wa] <= pos_wd;
            r_vel_mem[mem_wa] <= vel_wd;
        end
        r_pos_rd <= r_pos_mem[r_i];
        r_vel_rd <= r_vel_mem[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_swarm     <= RST_SWARM_SIZE;
            r_ar        <= RST_AVOID_RAD;
            r_cr        <= RST_COH_RAD;
            r_lr        <= RST_ALIGN_RAD;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SWARM_SIZE: r_swarm <= i_cfg_data[SWARM_W-1:0];
                    CFG_AVOID_RAD:  r_ar    <= i_cfg_data;
                    CFG_COH_RAD:    r_cr    <= i_cfg_data;
                    CFG_ALIGN_RAD:  r_lr    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_DONE && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_id   <= i_drone_id;
                r_bad  <= id_bad;
                r_self <= id_m1[AW-1:0];
                r_pn   <= i_pos_north;
                r_pe   <= i_pos_east;
                r_i    <= '0;
                r_k    <= '0;
                r_sn   <= '0;
                r_se   <= '0;
                r_cn   <= '0;
                r_ce   <= '0;
                r_an   <= '0;
                r_ae   <= '0;
                r_nsep <= '0;
                r_ncoh <= '0;
                r_nali <= '0;
            end
            ST_R2A: r_ar2 <= prod[RAD2_W-1:0];
            ST_R2C: r_cr2 <= prod[RAD2_W-1:0];
            ST_R2L: r_lr2 <= prod[RAD2_W-1:0];
            ST_WAIT: begin
                r_dn  <= dn_new;
                r_de  <= de_new;
                r_far <= far_n || far_e;
                r_vn  <= r_vel_rd[2*VEL_W-1:VEL_W];
                r_ve  <= r_vel_rd[VEL_W-1:0];
            end
            ST_SQN: r_d2 <= prod[DVD_W-1:0];
            ST_SQE: r_d2 <= r_d2 + prod[DVD_W-1:0];
            ST_TEST: begin
                if (in_sep) begin
                    r_nsep <= r_nsep + 1'b1;
                end else if (in_coh) begin
                    r_cn   <= r_cn - ACC_W'(dn26);
                    r_ce   <= r_ce - ACC_W'(de26);
                    r_ncoh <= r_ncoh + 1'b1;
                end
                if (in_ali) begin
                    r_an   <= r_an + ACC_W'(r_vn);
                    r_ae   <= r_ae + ACC_W'(r_ve);
                    r_nali <= r_nali + 1'b1;
                end
            end
            ST_SQRT: if (sq_rsp.done) r_dist <= sq_rsp.root;
            ST_KN, ST_KE: r_neg <= prod[2*MUL_W-1];
            ST_DIVN: if (div_rsp.done)
                r_sn <= r_neg ? r_sn - $signed(q48) : r_sn + $signed(q48);
            ST_DIVE: if (div_rsp.done)
                r_se <= r_neg ? r_se - $signed(q48) : r_se + $signed(q48);
            ST_NEXT: r_i <= r_i + 1'b1;
            ST_AVG: begin
                r_neg <= avg_acc[ACC_W-1];
                if (avg_cnt == '0) begin
                    r_avg[r_k] <= '0;
                    r_k <= r_k + 1'b1;
                end
            end
            ST_AVGW: if (div_rsp.done) begin
                r_avg[r_k] <= r_neg ? -q32 : q32;
                r_k <= r_k + 1'b1;
            end
            ST_DONE: if (out_free) begin
                r_o_id  <= r_id;
                r_o_bad <= r_bad;
                r_o_cn  <= r_bad ? '0 : r_avg[0];
                r_o_ce  <= r_bad ? '0 : r_avg[1];
                r_o_an  <= r_bad ? '0 : r_avg[2][VEL_W-1:0];
                r_o_ae  <= r_bad ? '0 : r_avg[3][VEL_W-1:0];
                r_o_sn  <= r_bad ? '0 : r_avg[4];
                r_o_se  <= r_bad ? '0 : r_avg[5];
            end
            default: ;
        endcase
    end

    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_target_id      = r_o_id;
    assign o_bad_id         = r_o_bad;
    assign o_cohesion_north = r_o_cn;
    assign o_cohesion_east  = r_o_ce;
    assign o_align_north    = r_o_an;
    assign o_align_east     = r_o_ae;
    assign o_separate_north = r_o_sn;
    assign o_separate_east  = r_o_se;

    `BFV_ASSERT_NEXT(a_accept_leaves_idle, in_acc, r_state != ST_IDLE)
    `BFV_ASSERT_IMP(a_div_go_when_free, div_req.go, !div_rsp.busy)
    `BFV_ASSERT_NEXT(a_done_loads_out, r_state == ST_DONE && out_free, o_out_valid)
    `BFV_ASSERT_IMP(a_counts_bounded, r_state == ST_AVG,
        ({1'b0, CW'(r_nsep)} + {1'b0, CW'(r_ncoh)}) <= {1'b0, n_eff})

endmodule

>>> tb/sv/tb_boids_flocking_vectors.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_boids_flocking_vectors
// Pings drones into the flocking vector block under random idling and
// back-pressure, predicts separation, cohesion and alignment per ping from
// its own copy of the drone tables and registers, and checks every result.
// ----------------------------------------------------------------------------
module tb_boids_flocking_vectors
    import bfv_pkg::*;
;

    typedef struct {
        logic [ID_W-1:0]         id;
        logic signed [POS_W-1:0] pn;
        logic signed [POS_W-1:0] pe;
        logic signed [VEL_W-1:0] vn;
        logic signed [VEL_W-1:0] ve;
        int                      gap;
        bit                      drain;
    } ping_t;

    typedef struct {
        logic [ID_W-1:0]         id;
        logic                    bad;
        logic signed [POS_W-1:0] cn;
        logic signed [POS_W-1:0] ce;
        logic signed [VEL_W-1:0] an;
        logic signed [VEL_W-1:0] ae;
        logic signed [POS_W-1:0] sn;
        logic signed [POS_W-1:0] se;
    } flock_vec_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [ID_W-1:0] i_drone_id = '0;
    logic signed [POS_W-1:0] i_pos_north = '0;
    logic signed [POS_W-1:0] i_pos_east = '0;
    logic signed [VEL_W-1:0] i_vel_north = '0;
    logic signed [VEL_W-1:0] i_vel_east = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [ID_W-1:0] o_target_id;
    logic o_bad_id;
    logic signed [POS_W-1:0] o_cohesion_north, o_cohesion_east;
    logic signed [VEL_W-1:0] o_align_north, o_align_east;
    logic signed [POS_W-1:0] o_separate_north, o_separate_east;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_SWARM_SIZE;
    logic [RAD_W-1:0] i_cfg_data = '0;

    boids_flocking_vectors dut (.*);

    always #5 i_clk = ~i_clk;

    ping_t      ping_q[$];
    flock_vec_t flock_q[$];
    int         n_errors = 0;

    int       tab_pn[BFV_MAX_DRONES];
    int       tab_pe[BFV_MAX_DRONES];
    shortint  tab_vn[BFV_MAX_DRONES];
    shortint  tab_ve[BFV_MAX_DRONES];
    longint   swarm_size = RST_SWARM_SIZE;
    longint   avoid_rad = RST_AVOID_RAD;
    longint   coh_rad = RST_COH_RAD;
    longint   align_rad = RST_ALIGN_RAD;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic flock_vec_t flock_vectors(ping_t p);
        flock_vec_t r;
        longint n, self, pn, pe, dn, de, d2, root_d, k;
        longint cn, ce, an, ae, sn, se, ncoh, nali, nsep;
        r = '{default: '0};
        r.id = p.id;
        n = (swarm_size > BFV_MAX_DRONES) ? BFV_MAX_DRONES : swarm_size;
        if (p.id == 0 || p.id > n) begin
            r.bad = 1'b1;
            return r;
        end
        self = p.id - 1;
        pn = p.pn;
        pe = p.pe;
        tab_pn[self] = p.pn;
        tab_pe[self] = p.pe;
        tab_vn[self] = p.vn;
        tab_ve[self] = p.ve;
        {cn, ce, an, ae, sn, se, ncoh, nali, nsep} = '0;
        for (int i = 0; i < n; i++) begin
            dn = pn - tab_pn[i];
            de = pe - tab_pe[i];
            if (dn >= (64'sd1 <<< 24) || -dn >= (64'sd1 <<< 24) ||
                de >= (64'sd1 <<< 24) || -de >= (64'sd1 <<< 24))
                continue;
            d2 = dn * dn + de * de;
            if (d2 < avoid_rad * avoid_rad && i != self) begin
                root_d = int_sqrt(d2);
                if (root_d != 0) begin
                    k = avoid_rad - root_d;
                    sn += (k * dn) / root_d;
                    se += (k * de) / root_d;
                end
                nsep++;
            end else if (d2 < coh_rad * coh_rad) begin
                cn -= dn;
                ce -= de;
                ncoh++;
            end
            if (d2 < align_rad * align_rad) begin
                an += tab_vn[i];
                ae += tab_ve[i];
                nali++;
            end
        end
        if (ncoh != 0) begin cn /= ncoh; ce /= ncoh; end
        if (nali != 0) begin an /= nali; ae /= nali; end
        if (nsep != 0) begin sn /= nsep; se /= nsep; end
        r.cn = cn[31:0];
        r.ce = ce[31:0];
        r.an = an[15:0];
        r.ae = ae[15:0];
        r.sn = sn[31:0];
        r.se = se[31:0];
        return r;
    endfunction

    // driver
    ping_t cur;
    bit    have = 0;
    int    gap_cnt = 0;

    always @(posedge i_clk) begin
        bit busy;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            busy = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                flock_q = {flock_q, flock_vectors('{i_drone_id, i_pos_north, i_pos_east,
                                                    i_vel_north, i_vel_east, 0, 0})};
                busy = 0;
            end
            if (!busy) begin
                if (!have && ping_q.size() > 0) begin
                    cur = ping_q.pop_front();
                    have = 1;
                    gap_cnt = cur.gap;
                end
                if (have && gap_cnt == 0 && (!cur.drain || flock_q.size() == 0)) begin
                    i_drone_id  <= cur.id;
                    i_pos_north <= cur.pn;
                    i_pos_east  <= cur.pe;
                    i_vel_north <= cur.vn;
                    i_vel_east  <= cur.ve;
                    i_in_valid  <= 1'b1;
                    have = 0;
                end else begin
                    i_in_valid <= 1'b0;
                    if (have && gap_cnt > 0) gap_cnt--;
                end
            end
        end
    end

    // monitor
    int n_seen = 0;
    int stall_cnt = 0;
    int hold_cnt = 0;

    always @(posedge i_clk) begin
        flock_vec_t e;
        if (o_out_valid && !i_out_stall) begin
            if (flock_q.size() == 0) begin
                $display("%0t: result with none expected, actual id %0d", $time, o_target_id);
                n_errors++;
            end else begin
                e = flock_q.pop_front();
                if (o_target_id !== e.id || o_bad_id !== e.bad ||
                    o_cohesion_north !== e.cn || o_cohesion_east !== e.ce ||
                    o_align_north !== e.an || o_align_east !== e.ae ||
                    o_separate_north !== e.sn || o_separate_east !== e.se) begin
                    $display("%0t: mismatch expected id=%0d bad=%0d coh=%0d,%0d ali=%0d,%0d sep=%0d,%0d",
                             $time, e.id, e.bad, e.cn, e.ce, e.an, e.ae, e.sn, e.se);
                    $display("%0t:          actual id=%0d bad=%0d coh=%0d,%0d ali=%0d,%0d sep=%0d,%0d",
                             $time, o_target_id, o_bad_id, o_cohesion_north, o_cohesion_east,
                             o_align_north, o_align_east, o_separate_north, o_separate_east);
                    n_errors++;
                end
            end
            n_seen++;
            if (n_seen == 300) hold_cnt = 3000;
            stall_cnt = ((n_seen / 150) % 4 == 3) ? 0 : $urandom_range(0, 12);
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_stall <= 1'b1;
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[RAD_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SWARM_SIZE: swarm_size = val & 64'h7F;
            CFG_AVOID_RAD:  avoid_rad = val & 64'hFFFFFF;
            CFG_COH_RAD:    coh_rad = val & 64'hFFFFFF;
            CFG_ALIGN_RAD:  align_rad = val & 64'hFFFFFF;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (ping_q.size() != 0 || have || i_in_valid || flock_q.size() != 0);
        repeat (5) @(posedge i_clk);
    endtask

    int n_queued = 0;

    task automatic add_ping(int id, longint pn, longint pe, int vn, int ve);
        ping_t p;
        p.id = id[ID_W-1:0];
        p.pn = pn[31:0];
        p.pe = pe[31:0];
        p.vn = vn[15:0];
        p.ve = ve[15:0];
        p.gap = ((n_queued / 100) % 5 == 4) ? 0 : $urandom_range(0, 12);
        p.drain = (n_queued % 400 == 399);
        ping_q = {ping_q, p};
        n_queued++;
    endtask

    task automatic random_pings(int count);
        longint scale, cx, ce, lim;
        int id, sel;
        lim = (swarm_size > BFV_MAX_DRONES) ? BFV_MAX_DRONES : swarm_size;
        scale = (avoid_rad > coh_rad) ? avoid_rad : coh_rad;
        if (align_rad > scale) scale = align_rad;
        if (scale == 0) scale = 4096;
        if (scale > 64'd16777216) scale = 64'd16777216;
        cx = $signed($urandom);
        ce = $signed($urandom);
        repeat (count) begin
            sel = $urandom_range(0, 19);
            id = (lim == 0) ? 0 : $urandom_range(1, lim);
            if (sel == 0) id = 0;
            else if (sel == 1) id = $urandom_range(0, 127);
            if (sel == 2)
                add_ping(id, $signed($urandom), $signed($urandom),
                         $urandom_range(0, 65535), $urandom_range(0, 65535));
            else
                add_ping(id, cx + longint'($urandom_range(0, 2 * scale)) - scale,
                         ce + longint'($urandom_range(0, 2 * scale)) - scale,
                         $urandom_range(0, 65535), $urandom_range(0, 65535));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_ping(0, 100, 100, 5, 5);
        add_ping(5, 100, 100, 5, 5);
        add_ping(127, 0, 0, 0, 0);
        add_ping(1, 0, 0, 256, -256);
        add_ping(2, 100, 0, 32767, -32768);
        add_ping(3, 0, 512, -32768, 32767);
        add_ping(4, 300, 300, 0, 1);
        add_ping(1, 0, 0, 1, 1);
        add_ping(2, 2147483647, -2147483648, 7, 7);
        add_ping(3, -2147483648, 2147483647, -7, -7);
        add_ping(4, 16777215, 0, 3, 3);
        add_ping(1, 16777216, 0, 3, 3);
        add_ping(2, -5000, 4000, 100, -100);
        add_ping(3, -5120, 0, 0, 0);
        add_ping(4, 2559, 0, 9, 9);
        add_ping(1, 2560, 0, 9, 9);
        random_pings(180);
        wait_idle();

        write_reg(CFG_SWARM_SIZE, 8);
        write_reg(CFG_AVOID_RAD, 2048);
        write_reg(CFG_COH_RAD, 8192);
        write_reg(CFG_ALIGN_RAD, 4096);
        random_pings(300);
        wait_idle();

        write_reg(CFG_SWARM_SIZE, 1);
        random_pings(60);
        wait_idle();

        write_reg(CFG_SWARM_SIZE, 0);
        random_pings(20);
        wait_idle();

        write_reg(CFG_SWARM_SIZE, 6);
        write_reg(CFG_AVOID_RAD, 0);
        write_reg(CFG_COH_RAD, 0);
        write_reg(CFG_ALIGN_RAD, 0);
        random_pings(150);
        wait_idle();

        write_reg(CFG_SWARM_SIZE, 5);
        write_reg(CFG_AVOID_RAD, 24'hFFFFFF);
        write_reg(CFG_COH_RAD, 24'hFFFFFF);
        write_reg(CFG_ALIGN_RAD, 24'hFFFFFF);
        random_pings(200);
        wait_idle();

        write_reg(CFG_SWARM_SIZE, 64);
        write_reg(CFG_AVOID_RAD, 300);
        write_reg(CFG_COH_RAD, 1000000);
        write_reg(CFG_ALIGN_RAD, 500000);
        random_pings(40);
        wait_idle();

        write_reg(CFG_SWARM_SIZE, 127);
        random_pings(30);
        wait_idle();

        write_reg(CFG_SWARM_SIZE, 7);
        write_reg(CFG_AVOID_RAD, 40000);
        write_reg(CFG_COH_RAD, 20000);
        write_reg(CFG_ALIGN_RAD, 30000);
        random_pings(400);
        wait_idle();

        write_reg(CFG_SWARM_SIZE, 3);
        write_reg(CFG_AVOID_RAD, 1024);
        write_reg(CFG_COH_RAD, 3000);
        write_reg(CFG_ALIGN_RAD, 2000);
        random_pings(400);
        wait_idle();

        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && flock_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #200ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
